@@ hdl/gha_pkg.sv @@
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types, codes and helpers of the generational handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

  // operation codes carried in the input tuser
  typedef enum logic [2:0] {
    MODE_ADD      = 3'd0,
    MODE_REMOVE   = 3'd1,
    MODE_VALIDATE = 3'd2,
    MODE_HANDLE   = 3'd3,
    MODE_NEXT     = 3'd4,
    MODE_FIRST    = 3'd5,
    MODE_CLEAR    = 3'd6
  } mode_t;

  localparam int GEN_W    = 16;
  localparam int HANDLE_W = 24;
  localparam int CAP_W    = 9;

  localparam logic [GEN_W-1:0] GEN_FIRST = 16'd1;
  localparam logic [GEN_W-1:0] GEN_LAST  = 16'hFFFF;
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  // one slot of the store
  typedef struct packed {
    logic             used;
    logic [GEN_W-1:0] gen;
  } slot_entry_t;

  // generation bump, skipping zero on wrap
  function automatic logic [GEN_W-1:0] gen_bump(input logic [GEN_W-1:0] g);
    return (g == GEN_LAST) ? GEN_FIRST : g + GEN_FIRST;
  endfunction

endpackage

@@ hdl/generational_handle_allocator_core.sv @@
// ----------------------------------------------------------------------------
// generational_handle_allocator_core
// Slot map with per-slot occupied bit and 16-bit generation in one memory.
// ----------------------------------------------------------------------------
// Operations arrive one beat at a time with the mode in s_tuser and are
// worked one at a time against a slot memory with one read port and one
// write port (read data registered). Remove, validate, handle-at-index
// and the unused mode issue the read in the accept cycle and check and
// write back in the next cycle. Add, next-occupied and first-occupied
// walk the memory one slot a cycle. Clear sweeps the whole built depth.
// After reset a clearing pass sets every slot free with generation 1 and
// holds s_tready low; capacity writes are taken at any time. A beat can
// be accepted while the previous result still sits in the output
// register; if that result has not left when the new one is ready, the
// new one waits in a hold register and s_tready stays low until it moves
// to the output register.
// ----------------------------------------------------------------------------
module generational_handle_allocator_core #(
  parameter int INDEX_BITS = 8,
  parameter int MAX_SLOTS  = 256
) (
  input  logic        clk,
  input  logic        rst,
  // capacity register write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data,     // slot_capacity
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,      // handle_in[23:0], slot_index[32:24], zero pad
  input  logic [2:0]  s_tuser,      // mode[2:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata       // success[0], handle_out[24:1], index_out[33:25],
                                    // live_count[42:34], zero pad
);

  localparam int AW = $clog2(MAX_SLOTS);
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int WA = (CW > INDEX_BITS) ? CW : INDEX_BITS;
  localparam int WW = (WA > gha_pkg::CAP_W) ? WA : gha_pkg::CAP_W;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_LOOK,
    S_SCAN,
    S_CLEAR,
    S_HOLD
  } state_t;

  state_t                        state;
  gha_pkg::mode_t                op;
  logic [gha_pkg::HANDLE_W-1:0]  hnd;
  logic [WW-1:0]                 cur;
  logic [CW-1:0]                 used_count;
  logic [CW-1:0]                 free_start;
  logic [gha_pkg::CAP_W-1:0]     cap_reg;
  logic [47:0]                   hold_data;

  gha_pkg::slot_entry_t          mem [MAX_SLOTS];
  gha_pkg::slot_entry_t          rd_data;
  gha_pkg::slot_entry_t          wr_data;
  logic [AW-1:0]                 rd_addr;
  logic [AW-1:0]                 wr_addr;
  logic                          mem_we;

  logic [WW-1:0]                 cap;
  logic [WW-1:0]                 cap_ext;
  logic [WW-1:0]                 in_idx;
  logic [WW-1:0]                 cur_inc;
  logic [WW-1:0]                 sidx_ext;
  logic [gha_pkg::HANDLE_W-1:0]  in_handle;
  gha_pkg::mode_t                in_mode;
  logic [gha_pkg::HANDLE_W-1:0]  hnd_shift;
  logic                          hnd_ok;
  logic                          scan_hit;
  logic                          out_free;
  logic                          out_load;

  logic                          res_fire;
  logic                          res_ok;
  logic [gha_pkg::HANDLE_W-1:0]  res_hout;
  logic [WW-1:0]                 res_idx;
  logic [CW-1:0]                 count_next;
  logic [CW-1:0]                 free_start_next;
  logic [47:0]                   res_data;

  // handle from generation and index
  function automatic logic [gha_pkg::HANDLE_W-1:0] make_handle(
    input logic [WW-1:0]            idx,
    input logic [gha_pkg::GEN_W-1:0] gen
  );
    logic [39:0] w;
    w = (40'(gen) << INDEX_BITS) | (40'(idx) & ((40'd1 << INDEX_BITS) - 40'd1));
    return w[gha_pkg::HANDLE_W-1:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign out_free  = !m_tvalid || m_tready;

  // effective capacity, clamped to 1..MAX_SLOTS
  always_comb begin
    cap_ext = WW'(cap_reg);
    if (cap_reg == '0) begin
      cap = WW'(1);
    end else if (cap_ext > WW'(MAX_SLOTS)) begin
      cap = WW'(MAX_SLOTS);
    end else begin
      cap = cap_ext;
    end
  end

  // first slot to look at for an incoming beat
  assign in_handle = s_tdata[23:0];
  assign in_mode   = gha_pkg::mode_t'(s_tuser);
  assign sidx_ext  = WW'(s_tdata[32:24]);
  assign cur_inc   = cur + WW'(1);

  always_comb begin
    unique case (in_mode)
      gha_pkg::MODE_ADD:      in_idx = (WW'(used_count) < cap) ? WW'(free_start) : cap;
      gha_pkg::MODE_REMOVE,
      gha_pkg::MODE_VALIDATE: in_idx = WW'(in_handle[INDEX_BITS-1:0]);
      gha_pkg::MODE_HANDLE:   in_idx = sidx_ext;
      gha_pkg::MODE_NEXT:     in_idx = (sidx_ext >= cap) ? cap : sidx_ext + WW'(1);
      default:                in_idx = '0;
    endcase
  end

  assign rd_addr = (state == S_IDLE) ? in_idx[AW-1:0] : cur_inc[AW-1:0];

  // handle check against the entry read for it
  assign hnd_shift = hnd >> INDEX_BITS;
  assign hnd_ok    = (hnd != '0) && (cur < cap) && rd_data.used &&
                     (rd_data.gen == hnd_shift[gha_pkg::GEN_W-1:0]);
  assign scan_hit  = (op == gha_pkg::MODE_ADD) ? !rd_data.used : rd_data.used;

  // result of the finishing cycle and memory write-back of each state
  always_comb begin
    res_fire        = 1'b0;
    res_ok          = 1'b0;
    res_hout        = '0;
    res_idx         = cap;
    count_next      = used_count;
    free_start_next = free_start;
    mem_we          = 1'b0;
    wr_addr         = cur[AW-1:0];
    wr_data         = rd_data;
    unique case (state)
      S_INIT: begin
        mem_we  = 1'b1;
        wr_data = '{used: 1'b0, gen: gha_pkg::GEN_FIRST};
      end
      S_LOOK: begin
        res_fire = 1'b1;
        unique case (op)
          gha_pkg::MODE_REMOVE: begin
            if (hnd_ok) begin
              res_ok  = 1'b1;
              res_idx = cur;
              mem_we  = 1'b1;
              wr_data = '{used: 1'b0, gen: gha_pkg::gen_bump(rd_data.gen)};
              if (used_count != '0) begin
                count_next = used_count - CW'(1);
              end
              if (cur < WW'(free_start)) begin
                free_start_next = CW'(cur);
              end
            end
          end
          gha_pkg::MODE_VALIDATE: begin
            if (hnd_ok) begin
              res_ok   = 1'b1;
              res_idx  = cur;
              res_hout = hnd;
            end
          end
          gha_pkg::MODE_HANDLE: begin
            if (cur < cap && rd_data.used) begin
              res_ok   = 1'b1;
              res_idx  = cur;
              res_hout = make_handle(cur, rd_data.gen);
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        if (cur >= cap) begin
          res_fire = 1'b1;
        end else if (scan_hit) begin
          res_fire = 1'b1;
          res_ok   = 1'b1;
          res_idx  = cur;
          res_hout = make_handle(cur, rd_data.gen);
          if (op == gha_pkg::MODE_ADD) begin
            mem_we          = 1'b1;
            wr_data         = '{used: 1'b1, gen: rd_data.gen};
            count_next      = used_count + CW'(1);
            free_start_next = CW'(cur_inc);
          end
        end
      end
      S_CLEAR: begin
        if (rd_data.used) begin
          mem_we  = 1'b1;
          wr_data = '{used: 1'b0, gen: gha_pkg::gen_bump(rd_data.gen)};
        end
        if (cur == WW'(MAX_SLOTS - 1)) begin
          res_fire        = 1'b1;
          count_next      = '0;
          free_start_next = '0;
        end
      end
      default: begin
      end
    endcase
    res_data = {5'b0, 9'(count_next), 9'(res_idx), res_hout, res_ok};
  end

  // a result moves into the output register this cycle
  assign out_load = out_free && (res_fire || (state == S_HOLD));

  // slot memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // control state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      cur        <= '0;
      used_count <= '0;
      free_start <= '0;
      cap_reg    <= gha_pkg::CAP_RESET;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cap_reg <= cfg_data;
      end
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          cur <= cur_inc;
          if (cur == WW'(MAX_SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            op  <= in_mode;
            hnd <= in_handle;
            cur <= in_idx;
            unique case (in_mode)
              gha_pkg::MODE_ADD,
              gha_pkg::MODE_NEXT,
              gha_pkg::MODE_FIRST: state <= S_SCAN;
              gha_pkg::MODE_CLEAR: state <= S_CLEAR;
              default:             state <= S_LOOK;
            endcase
          end
        end
        S_SCAN, S_CLEAR: begin
          if (!res_fire) begin
            cur <= cur_inc;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            m_tdata  <= hold_data;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
        end
      endcase
      // finished operation: commit counters and hand the result on
      if (res_fire) begin
        used_count <= count_next;
        free_start <= free_start_next;
        if (out_free) begin
          m_tdata  <= res_data;
          m_tvalid <= 1'b1;
          state    <= S_IDLE;
        end else begin
          hold_data <= res_data;
          state     <= S_HOLD;
        end
      end
    end
  end

`ifndef SYNTHESIS
  // live count can never pass the built depth
  assert property (@(posedge clk) disable iff (rst) used_count <= CW'(MAX_SLOTS))
    else $error("live count above depth");

  // a held result means the output register is still occupied
  assert property (@(posedge clk) disable iff (rst) (state == S_HOLD) |-> m_tvalid)
    else $error("result held while output is empty");

  // one operation at a time
  assert property (@(posedge clk) disable iff (rst) (s_tvalid && s_tready) |=> !s_tready)
    else $error("beat accepted while busy");

  // no memory write-back unless an operation or the init pass runs
  assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state != S_IDLE && state != S_HOLD))
    else $error("slot write while idle");
`endif

endmodule
